// ===== src/bmp_pkg.sv =====
// bmp_pkg: shared types and constants of the bad pixel mask painter
// field widths of the stream payload, action codes, column split status
// no dependencies
package bmp_pkg;

  localparam int ACTION_W    = 2;
  localparam int COORD_W     = 9;
  localparam int TIME_W      = 64;
  localparam int WSEL_W      = 3;
  localparam int OUT_WORD_W  = 64;
  localparam int S_TDATA_W   = 168;
  localparam int M_TDATA_W   = 80;

  // fixed-point reciprocal shift used to split a pixel index into word and bit
  localparam int RECIP_SHIFT = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    logic done;
    logic spill;
  } span_stat_t;

endpackage

// ===== src/bmp_mask_mem.sv =====
// bmp_mask_mem: single write port, single read port mask storage
// read data registered; no reset, contents set by the sweep in the core
// depends on nothing
module bmp_mask_mem #(
  parameter int DEPTH = 2304,
  parameter int WIDTH = 64,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bmp_col_split.sv =====
// bmp_col_split: splits the first 0-based pixel column of a span into a
// word index and bit masks for up to two neighboring words, three stages
// depends on bmp_pkg
module bmp_col_split
  import bmp_pkg::*;
#(
  parameter int WORD_BITS = 64,
  parameter int WIW       = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [COORD_W-1:0]   p0,
  input  logic [1:0]           n,
  output span_stat_t           stat,
  output logic [WIW-1:0]       word_idx,
  output logic [WORD_BITS-1:0] mask0,
  output logic [WORD_BITS-1:0] mask1
);

  localparam int RECIP  = (1 << RECIP_SHIFT) / WORD_BITS;
  localparam int RCP_W  = $clog2(RECIP + 1);
  localparam int PROD_W = COORD_W + RCP_W;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int LIM_W  = BW + 2;

  logic               v1, v2;
  logic [COORD_W-1:0] p1;
  logic [1:0]         n1, n2;
  logic [PROD_W-1:0]  prod1;
  logic [COORD_W-1:0] q2;
  logic [BW-1:0]      b2;

  logic [COORD_W-1:0]   q0, qwb, r0;
  logic                 corr;
  logic [LIM_W-1:0]     lim;
  logic [WORD_BITS-1:0] m0_next, m1_next;

  // estimate may be one short, fixed by one compare and subtract
  always_comb begin
    q0   = COORD_W'(prod1 >> RECIP_SHIFT);
    qwb  = COORD_W'(q0 * COORD_W'(WORD_BITS));
    r0   = p1 - qwb;
    corr = (r0 >= COORD_W'(WORD_BITS));
  end

  always_comb begin
    lim = LIM_W'(b2) + LIM_W'(n2);
    for (int i = 0; i < WORD_BITS; i++) begin
      m0_next[i] = (i >= int'(b2)) && (i < int'(lim));
      m1_next[i] = (i + WORD_BITS < int'(lim));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      v1        <= start;
      v2        <= v1;
      stat.done <= v2;
    end
    if (start) begin
      p1    <= p0;
      n1    <= n;
      prod1 <= PROD_W'(p0) * PROD_W'(RECIP);
    end
    if (v1) begin
      q2 <= corr ? q0 + COORD_W'(1) : q0;
      b2 <= corr ? BW'(r0 - COORD_W'(WORD_BITS)) : BW'(r0);
      n2 <= n1;
    end
    if (v2) begin
      word_idx   <= WIW'(q2);
      mask0      <= m0_next;
      mask1      <= m1_next;
      stat.spill <= |m1_next;
    end
  end

endmodule

// ===== src/bad_pixel_mask_painter_core.sv =====
// bad_pixel_mask_painter_core: one-bit-per-pixel detector mask with clear,
// rectangle paint and word read, plus the APB register port
// depends on bmp_pkg, bmp_mask_mem, bmp_col_split
//
// Items arrive on the s_ stream (action in s_tuser), read results leave on
// the m_ stream, observation_time is written over APB at address 0.
// One item is worked at a time; s_tready is high only while idle.
// Clear: the mask is swept back to all ones, one word a cycle, over all
// MASK_HEIGHT * ceil(MASK_WIDTH / WORD_BITS) words (2304 by default).
// Apply: the time window and clamps are checked, then the column split
// unit runs, then the shared read-modify-write path walks the rectangle,
// one word per row, two when the three columns straddle a word boundary.
// An entry outside its window or off the sensor goes back to idle unpainted.
// Read: address multiply, memory read and output load; the output load
// waits until the output register is free.
// Reset runs the same clearing sweep before the first item is taken.
// A stalled receiver holds the result in the output register; the block
// still takes clear and apply items, and a read waits for the register.
module bad_pixel_mask_painter_core
  import bmp_pkg::*;
#(
  parameter int MASK_WIDTH  = 384,
  parameter int MASK_HEIGHT = 384,
  parameter int WORD_BITS   = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // column, first_row, row_extent, time_start, time_end, read_row, read_word
  input  logic [S_TDATA_W-1:0] s_tdata,
  // action
  input  logic [ACTION_W-1:0]  s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // mask_word, echo_row, echo_word
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int ROW_WORDS = (MASK_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH     = MASK_HEIGHT * ROW_WORDS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int RW        = (MASK_HEIGHT > 1) ? $clog2(MASK_HEIGHT) : 1;
  localparam int CW        = $clog2(MASK_WIDTH + MASK_HEIGHT + 1024);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SPLIT, S_RD0, S_WR0, S_RD1, S_WR1,
    S_RADDR, S_RMEM, S_RDATA
  } state_t;

  state_t state;

  logic signed [TIME_W-1:0] obs_time;
  logic [AW-1:0]            clr_addr;

  // latched item
  logic [COORD_W-1:0]       col_r, row_r, ext_r, rrow_r;
  logic [WSEL_W-1:0]        rword_r;
  logic signed [TIME_W-1:0] ts_r, te_r;

  logic [RW-1:0]            row_cur, row_last;
  logic [AW-1:0]            base;
  logic                     rd_ok;
  logic [AW-1:0]            rd_addr;

  logic [OUT_WORD_W-1:0]    out_word;
  logic [COORD_W-1:0]       out_row;
  logic [WSEL_W-1:0]        out_sel;

  // clamp and window logic
  logic [CW-1:0]            ylo, yhi, xlo, xhi, yhi_raw, xhi_raw;
  logic                     win_ok, paint;
  logic [COORD_W-1:0]       span_p0;
  logic [1:0]               span_n;
  logic [AW-1:0]            base_calc;

  // span unit
  span_stat_t               span_stat;
  logic [WIW-1:0]           span_word;
  logic [WORD_BITS-1:0]     span_mask0, span_mask1;

  // memory port
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr, addr0, addr1;
  logic [WORD_BITS-1:0]     mem_wdata, mem_rdata;

  logic                     in_xfer, cfg_wr, out_free;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && !paddr[3];
  assign prdata   = paddr[3] ? 64'd0 : obs_time;
  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {4'd0, out_sel, out_row, out_word};

  always_comb begin
    ylo     = (CW'(row_r) <= CW'(1)) ? CW'(1) : CW'(row_r) - CW'(1);
    yhi_raw = CW'(row_r) + CW'(ext_r);
    yhi     = (yhi_raw > CW'(MASK_HEIGHT)) ? CW'(MASK_HEIGHT) : yhi_raw;
    xlo     = (CW'(col_r) <= CW'(1)) ? CW'(1) : CW'(col_r) - CW'(1);
    xhi_raw = CW'(col_r) + CW'(1);
    xhi     = (xhi_raw > CW'(MASK_WIDTH)) ? CW'(MASK_WIDTH) : xhi_raw;
    win_ok  = (obs_time >= ts_r) && (obs_time < te_r);
    paint   = win_ok && (ylo <= yhi) && (xlo <= xhi);
    span_p0 = COORD_W'(xlo - CW'(1));
    span_n  = 2'(xhi - xlo + CW'(1));
  end

  assign base_calc = AW'(row_cur) * AW'(ROW_WORDS);
  assign addr0     = base + AW'(span_word);
  assign addr1     = addr0 + AW'(1);

  bmp_col_split #(
    .WORD_BITS (WORD_BITS),
    .WIW       (WIW)
  ) u_col_split (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_CHECK) && paint),
    .p0       (span_p0),
    .n        (span_n),
    .stat     (span_stat),
    .word_idx (span_word),
    .mask0    (span_mask0),
    .mask1    (span_mask1)
  );

  // shared read-modify-write path, also the clearing sweep and the word read
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = {WORD_BITS{1'b1}};
    mem_re    = 1'b0;
    mem_raddr = addr0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_RD0: begin
        mem_re = 1'b1;
      end
      S_WR0: begin
        mem_we    = 1'b1;
        mem_waddr = addr0;
        mem_wdata = mem_rdata & ~span_mask0;
      end
      S_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = addr1;
      end
      S_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = addr1;
        mem_wdata = mem_rdata & ~span_mask1;
      end
      S_RMEM: begin
        mem_re    = rd_ok;
        mem_raddr = rd_addr;
      end
      default: begin
      end
    endcase
  end

  bmp_mask_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mask_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      obs_time <= '0;
    end else begin
      if (cfg_wr) begin
        obs_time <= pwdata;
      end
      // load a new result, or drop the one the receiver has taken
      if ((state == S_RDATA) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            col_r   <= s_tdata[8:0];
            row_r   <= s_tdata[17:9];
            ext_r   <= s_tdata[26:18];
            ts_r    <= s_tdata[90:27];
            te_r    <= s_tdata[154:91];
            rrow_r  <= s_tdata[163:155];
            rword_r <= s_tdata[166:164];
            case (action_t'(s_tuser))
              ACT_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              ACT_APPLY: state <= S_CHECK;
              ACT_READ:  state <= S_RADDR;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_CHECK: begin
          row_cur  <= RW'(ylo - CW'(1));
          row_last <= RW'(yhi - CW'(1));
          state    <= paint ? S_SPLIT : S_IDLE;
        end
        S_SPLIT: begin
          base <= base_calc;
          if (span_stat.done) begin
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_WR0;
        S_WR0: begin
          if (span_stat.spill) begin
            state <= S_RD1;
          end else if (row_cur == row_last) begin
            state <= S_IDLE;
          end else begin
            row_cur <= row_cur + RW'(1);
            base    <= base + AW'(ROW_WORDS);
            state   <= S_RD0;
          end
        end
        S_RD1: state <= S_WR1;
        S_WR1: begin
          if (row_cur == row_last) begin
            state <= S_IDLE;
          end else begin
            row_cur <= row_cur + RW'(1);
            base    <= base + AW'(ROW_WORDS);
            state   <= S_RD0;
          end
        end
        S_RADDR: begin
          rd_ok   <= (32'(rrow_r) < 32'(MASK_HEIGHT)) && (32'(rword_r) < 32'(ROW_WORDS));
          rd_addr <= AW'(rrow_r) * AW'(ROW_WORDS) + AW'(rword_r);
          state   <= S_RMEM;
        end
        S_RMEM: state <= S_RDATA;
        S_RDATA: begin
          if (out_free) begin
            out_word <= rd_ok ? OUT_WORD_W'(mem_rdata) : '0;
            out_row  <= rrow_r;
            out_sel  <= rword_r;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < 32'(DEPTH)))
    else $error("mask write address beyond the mask");

  a_raddr_range: assert property (@(posedge clk) disable iff (rst)
    (mem_re && state != S_RMEM) |-> (32'(mem_raddr) < 32'(DEPTH)))
    else $error("paint read address beyond the mask");

  a_spill_mask: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR1) |-> (span_mask1 != '0))
    else $error("second word written with an empty mask");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(out_word))
    else $error("pending result overwritten");

endmodule

// ===== tb/tb_bad_pixel_mask_painter_core.sv =====
// tb_bad_pixel_mask_painter_core: self-checking testbench for the bad pixel mask painter
// keeps its own copy of the mask, predicts every read word and checks the m_ stream
// depends on bmp_pkg and bad_pixel_mask_painter_core
`timescale 1ns / 100ps

module tb_bad_pixel_mask_painter_core
  import bmp_pkg::*;
();

  localparam int SENSOR_W      = 384;
  localparam int SENSOR_H      = 384;
  localparam int WORD_W        = 64;
  localparam int ROW_WORDS     = (SENSOR_W + WORD_W - 1) / WORD_W;
  localparam int SETTLE_CYCLES = 2600;   // clear sweep plus margin
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 20000;

  localparam logic [3:0]  OBS_TIME_ADDR = 4'd0;
  localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    action_t     act;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [8:0]  ext;
    logic [63:0] ts;
    logic [63:0] te;
    logic [8:0]  rrow;
    logic [2:0]  rword;
  } item_t;

  typedef struct {
    logic [63:0] mask_word;
    logic [8:0]  row;
    logic [2:0]  word;
  } word_read_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel, penable, pwrite, pready;
  logic [3:0]           paddr;
  logic [63:0]          pwdata, prdata;
  logic                 s_tvalid, s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [ACTION_W-1:0]  s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // predicted mask and configuration
  logic [63:0] mask_mem [0:SENSOR_H*ROW_WORDS-1];
  logic [63:0] obs_time;
  word_read_t  pending_reads [$];

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int errors = 0, items_sent = 0, reads_checked = 0, config_writes = 0;

  bad_pixel_mask_painter_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // column, first_row, row_extent, time_start, time_end, read_row, read_word
  function automatic logic [S_TDATA_W-1:0] pack_item(input item_t it);
    return {1'b0, it.rword, it.rrow, it.te, it.ts, it.ext, it.row, it.col};
  endfunction

  function automatic item_t blank_item(input action_t a);
    item_t it;
    it.act = a;
    it.col = '0; it.row = '0; it.ext = '0;
    it.ts = '0; it.te = '0;
    it.rrow = '0; it.rword = '0;
    return it;
  endfunction

  function automatic item_t read_item(input int r, input int w);
    item_t it;
    it = blank_item(ACT_READ);
    it.rrow = r[8:0];
    it.rword = w[2:0];
    return it;
  endfunction

  function automatic item_t apply_item(input int c, input int r, input int e,
                                       input logic [63:0] ts, input logic [63:0] te);
    item_t it;
    it = blank_item(ACT_APPLY);
    it.col = c[8:0]; it.row = r[8:0]; it.ext = e[8:0];
    it.ts = ts; it.te = te;
    return it;
  endfunction

  function automatic void fill_mask_good();
    foreach (mask_mem[i]) mask_mem[i] = '1;
  endfunction

  function automatic void paint_rectangle(input item_t it);
    int ylo, yhi, xlo, xhi, p;
    if (!($signed(obs_time) >= $signed(it.ts) && $signed(obs_time) < $signed(it.te)))
      return;
    ylo = int'(it.row) - 1 < 1 ? 1 : int'(it.row) - 1;
    yhi = int'(it.row) + int'(it.ext) > SENSOR_H ? SENSOR_H : int'(it.row) + int'(it.ext);
    xlo = int'(it.col) - 1 < 1 ? 1 : int'(it.col) - 1;
    xhi = int'(it.col) + 1 > SENSOR_W ? SENSOR_W : int'(it.col) + 1;
    for (int y = ylo; y <= yhi; y++) begin
      for (int x = xlo; x <= xhi; x++) begin
        p = x - 1;
        mask_mem[(y - 1) * ROW_WORDS + p / WORD_W][p % WORD_W] = 1'b0;
      end
    end
  endfunction

  // update the predicted mask for one accepted item
  function automatic void track_item(input item_t it);
    word_read_t r;
    items_sent++;
    case (it.act)
      ACT_CLEAR: fill_mask_good();
      ACT_APPLY: paint_rectangle(it);
      ACT_READ: begin
        r.row = it.rrow;
        r.word = it.rword;
        if (int'(it.rrow) < SENSOR_H && int'(it.rword) < ROW_WORDS)
          r.mask_word = mask_mem[int'(it.rrow) * ROW_WORDS + int'(it.rword)];
        else
          r.mask_word = '0;
        pending_reads = {pending_reads, r};
      end
      default: ;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input item_t it);
    if (!steady && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_item(it);
    s_tuser  <= it.act;
    do @(posedge clk); while (!s_tready);
    track_item(it);
    @(negedge clk);
  endtask

  // drain results and let a clear sweep or a long paint finish
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_obs_time(input logic [63:0] value);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OBS_TIME_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    obs_time = value;
    config_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic pick_window(output logic [63:0] ts, output logic [63:0] te);
    case ($urandom_range(9))
      0, 1, 2, 3: begin ts = T_MIN; te = T_MAX; end
      4: begin ts = obs_time; te = obs_time + 1; end
      5: begin
        ts = obs_time - $urandom_range(0, 1000);
        te = obs_time + $urandom_range(1, 1000);
      end
      6: begin ts = obs_time + 1; te = T_MAX; end
      7: begin ts = T_MIN; te = obs_time; end
      default: begin ts = rand64(); te = rand64(); end
    endcase
  endtask

  // received word check
  always @(posedge clk) begin
    word_read_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t unexpected mask word transfer: %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (m_tdata[63:0] !== want.mask_word) begin
          $display("%0t mask_word mismatch: expected %h actual %h",
                   $time, want.mask_word, m_tdata[63:0]);
          errors++;
        end
        if (m_tdata[72:64] !== want.row) begin
          $display("%0t echo_row mismatch: expected %0d actual %0d",
                   $time, want.row, m_tdata[72:64]);
          errors++;
        end
        if (m_tdata[75:73] !== want.word) begin
          $display("%0t echo_word mismatch: expected %0d actual %0d",
                   $time, want.word, m_tdata[75:73]);
          errors++;
        end
      end
    end
  end

  // receiver: random idling, or a long hold when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset_state();
    send_item(read_item(0, 0));
    send_item(read_item(383, 5));
    send_item(read_item(384, 0));
    send_item(read_item(0, 6));
    send_item(read_item(511, 7));
  endtask

  task automatic test_directed_paint();
    item_t it;
    send_item(apply_item(1, 1, 0, T_MIN, T_MAX));        // top-left corner
    send_item(read_item(0, 0));
    send_item(read_item(1, 0));
    send_item(apply_item(384, 384, 384, T_MIN, T_MAX));  // bottom-right corner
    send_item(read_item(383, 5));
    send_item(apply_item(64, 10, 2, T_MIN, T_MAX));      // three columns across a word edge
    send_item(read_item(9, 0));
    send_item(read_item(11, 1));
    send_item(apply_item(200, 200, 3, 64'd0, 64'd0));    // empty window
    send_item(read_item(199, 3));
    send_item(apply_item(100, 50, 0, 64'd1, T_MAX));     // starts after now
    send_item(apply_item(100, 60, 0, T_MIN, 64'd0));     // end is exclusive
    send_item(apply_item(100, 70, 0, 64'd0, 64'd1));     // start is inclusive
    send_item(read_item(49, 1));
    send_item(read_item(59, 1));
    send_item(read_item(69, 1));
    send_item(apply_item(0, 0, 5, T_MIN, T_MAX));        // zero column and row
    send_item(read_item(4, 0));
    send_item(apply_item(386, 20, 0, T_MIN, T_MAX));     // off the sensor
    send_item(apply_item(511, 511, 511, T_MIN, T_MAX));
    send_item(read_item(19, 5));
    it = apply_item(511, 511, 511, '1, '1);
    it.act = ACT_NOP;
    it.rrow = '1;
    it.rword = '1;
    send_item(it);
    send_item(read_item(383, 5));
    send_item(blank_item(ACT_CLEAR));
    send_item(read_item(0, 0));
  endtask

  task automatic test_time_extremes();
    logic [63:0] settings [4];
    logic [63:0] ts, te;
    settings = '{T_MIN, T_MAX, '1, rand64()};
    foreach (settings[i]) begin
      write_obs_time(settings[i]);
      send_item(blank_item(ACT_CLEAR));
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: begin ts = T_MIN; te = T_MAX; end
          1: begin ts = obs_time; te = obs_time + 1; end
          2: begin ts = obs_time; te = T_MAX; end
          default: begin ts = T_MIN; te = obs_time; end
        endcase
        send_item(apply_item(50 + 70 * k, 30 + 40 * k, 1, ts, te));
        send_item(read_item(29 + 40 * k, (49 + 70 * k) / WORD_W));
      end
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int first, c, r, e, sel;
    logic [63:0] ts, te;
    item_t it;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ((items_sent - first) % 110 < 3 && items_sent - first >= 3)
        write_obs_time($urandom_range(1) ? rand64() : 64'($signed($urandom_range(0, 200)) - 100));
      steady = (items_sent - first >= 150) && (items_sent - first < 260);
      sel = $urandom_range(99);
      if (sel < 55) begin
        // entry followed by reads around its rectangle
        c = $urandom_range(1, SENSOR_W);
        r = $urandom_range(1, SENSOR_H);
        case ($urandom_range(19))
          0: e = $urandom_range(0, 511);
          1, 2: e = $urandom_range(0, 40);
          default: e = $urandom_range(0, 6);
        endcase
        pick_window(ts, te);
        send_item(apply_item(c, r, e, ts, te));
        repeat ($urandom_range(1, 3)) begin
          send_item(read_item(clamp_int(r - 2 + $urandom_range(0, e + 2), 0, SENSOR_H - 1),
                              clamp_int((c - 2 + $urandom_range(0, 2)) / WORD_W, 0,
                                        ROW_WORDS - 1)));
        end
      end else if (sel < 80) begin
        send_item(read_item($urandom_range(9) ? $urandom_range(0, SENSOR_H - 1)
                                              : $urandom_range(0, 511),
                            $urandom_range(9) ? $urandom_range(0, ROW_WORDS - 1)
                                              : $urandom_range(0, 7)));
      end else if (sel < 97) begin
        // full-range fields, as apply or as no operation
        it = apply_item($urandom_range(0, 511), $urandom_range(0, 511),
                        $urandom_range(0, 15), rand64(), rand64());
        if ($urandom_range(3) == 0) it.ext = 9'($urandom_range(0, 511));
        it.rrow = 9'($urandom_range(0, 511));
        it.rword = 3'($urandom_range(0, 7));
        if (sel >= 93) it.act = ACT_NOP;
        send_item(it);
      end else begin
        send_item(blank_item(ACT_CLEAR));
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    settle_block();
    steady = 1'b1;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (int k = 0; k < 8; k++) begin
      if (k % 3 == 1)
        send_item(apply_item($urandom_range(1, SENSOR_W), 5 * k + 1, 2, T_MIN, T_MAX));
      else
        send_item(read_item(5 * k, k % ROW_WORDS));
    end
    steady = 1'b0;
  endtask

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = ACT_NOP;
    obs_time = '0;
    fill_mask_good();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_paint();
    test_time_extremes();
    write_obs_time('0);
    test_random_traffic(440);
    test_backpressure();
    settle_block();

    $display("run covered %0d items and %0d checked mask words over %0d time settings,",
             items_sent, reads_checked, config_writes);
    $display("with corner and off-sensor entries, window edges and a long receiver hold");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
